// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/vtp_pkg.sv =====
// Types and constants for the vertex transform and project core.
// Depends on nothing.
package vtp_pkg;
	localparam logic [1:0] OP_LOAD_ROW = 2'd0;
	localparam logic [1:0] OP_COMPOSE  = 2'd1;
	localparam logic [1:0] OP_VERTEX   = 2'd2;

	localparam logic [2:0] REG_CAM_ROW0  = 3'd0;
	localparam logic [2:0] REG_CAM_ROW1  = 3'd1;
	localparam logic [2:0] REG_CAM_ROW2  = 3'd2;
	localparam logic [2:0] REG_CAM_TXY   = 3'd3;
	localparam logic [2:0] REG_CAM_TZ    = 3'd4;
	localparam logic [2:0] REG_PROJ_DIST = 3'd5;
	localparam logic [2:0] REG_SCR_OFF   = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_STORE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_FINISH,
		ST_OUT
	} state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic       load_in;
		logic       clear_acc;
		logic       mac;
		logic [1:0] k;
		logic [1:0] i;
		logic [1:0] j;
		logic       is_trans;
		logic       store_vm;
		logic       store_vt;
		logic       store_w;
		logic       div_start;
		logic       div_axis;
		logic       finish_axis;
		logic       out_load;
	} cmd_t;

	// op is the operation held for the item in flight, in_op the one offered at the input
	typedef struct packed {
		logic [1:0] op;
		logic [1:0] in_op;
		logic       div_busy;
	} stat_t;
endpackage

// ===== rtl/core/vtp_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on nothing.
module vtp_div #(
	parameter int NW = 56,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted = {r_q[DW-1:0], q_q[NW-1]};
	assign trial   = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[DW]) begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = q_q;
	assign rem  = r_q[DW-1:0];
endmodule

// ===== rtl/core/vtp_ctrl.sv =====
// Sequencer for loads, compose and vertex transform.
// Depends on vtp_pkg.
module vtp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  vtp_pkg::stat_t stat,
	output vtp_pkg::cmd_t  cmd
);
	import vtp_pkg::*;
	state_t st_q, st_d;
	logic [1:0] i_q, j_q, k_q;
	logic       tr_q, ax_q, ov_q;
	logic       last_k, last_col;

	assign last_k   = (k_q == 2'd2);
	// compose walks j=0..2 then the translation column; vertex only does the translation slot
	assign last_col = tr_q;
	assign in_ready = (st_q == ST_IDLE) && !ov_q;
	assign out_valid = ov_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (in_valid && in_ready) begin
				st_d = ST_IDLE;
			end else if (1'b0) begin
				st_d = ST_IDLE;
			end
			ST_MAC:       if (last_k) st_d = ST_STORE;
			ST_STORE: begin
				if (last_col && i_q == 2'd2)
					st_d = (stat.op == OP_VERTEX) ? ST_DIV_START : ST_IDLE;
				else
					st_d = ST_MAC;
			end
			ST_DIV_START: st_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (!stat.div_busy) st_d = ST_FINISH;
			ST_FINISH:    st_d = ax_q ? ST_OUT : ST_DIV_START;
			ST_OUT:       st_d = ST_IDLE;
			default:      st_d = ST_IDLE;
		endcase
		if (st_q == ST_IDLE && in_valid && in_ready &&
		    (stat.in_op == OP_COMPOSE || stat.in_op == OP_VERTEX))
			st_d = ST_MAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			i_q <= '0; j_q <= '0; k_q <= '0; tr_q <= 1'b0; ax_q <= 1'b0; ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_OUT) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					i_q <= '0; j_q <= '0; k_q <= '0; ax_q <= 1'b0;
					tr_q <= (stat.in_op == OP_VERTEX);
				end
				ST_MAC: k_q <= k_q + 2'd1;
				ST_STORE: begin
					k_q <= '0;
					if (stat.op == OP_VERTEX) begin
						tr_q <= 1'b1;
						i_q <= i_q + 2'd1;
					end else if (tr_q) begin
						tr_q <= 1'b0; j_q <= '0; i_q <= i_q + 2'd1;
					end else if (j_q == 2'd2) begin
						tr_q <= 1'b1;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				ST_FINISH: ax_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.load_in     = (st_q == ST_IDLE) && in_valid && in_ready;
		cmd.clear_acc   = (st_q == ST_IDLE) || (st_q == ST_STORE);
		cmd.mac         = (st_q == ST_MAC);
		cmd.k           = k_q;
		cmd.i           = i_q;
		cmd.j           = j_q;
		cmd.is_trans    = tr_q;
		cmd.store_vm    = (st_q == ST_STORE) && (stat.op == OP_COMPOSE) && !tr_q;
		cmd.store_vt    = (st_q == ST_STORE) && (stat.op == OP_COMPOSE) && tr_q;
		cmd.store_w     = (st_q == ST_STORE) && (stat.op == OP_VERTEX);
		cmd.div_start   = (st_q == ST_DIV_START);
		cmd.div_axis    = ax_q;
		cmd.finish_axis = (st_q == ST_FINISH);
		cmd.out_load    = (st_q == ST_OUT);
	end
endmodule

// ===== rtl/core/vtp_datapath.sv =====
// Shared multiply-accumulate, matrix state, divider and projection clamp.
// Depends on vtp_pkg and vtp_div.
module vtp_datapath #(
	parameter int SCREEN_FRAC_BITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic [1:0]         operation,
	input  logic [1:0]         row_index,
	input  logic signed [15:0] elem_a,
	input  logic signed [15:0] elem_b,
	input  logic signed [15:0] elem_c,
	input  logic signed [7:0]  vert_x,
	input  logic signed [7:0]  vert_y,
	input  logic signed [7:0]  vert_z,
	input  logic [23:0]        color_word,
	input  logic [7:0]         uv_u,
	input  logic [7:0]         uv_v,
	input  vtp_pkg::cmd_t      cmd,
	output vtp_pkg::stat_t     stat,
	output logic signed [14:0] screen_x,
	output logic signed [14:0] screen_y,
	output logic [30:0]        depth_z,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         tex_u,
	output logic [7:0]         tex_v
);
	import vtp_pkg::*;
	localparam int SH = 16 - SCREEN_FRAC_BITS;

	logic [47:0] cam_q [3];
	logic signed [31:0] ct_q [3];
	logic [15:0] h_q;
	logic signed [31:0] off_q [2];
	logic signed [15:0] om_q [9];
	logic signed [17:0] vm_q [9];
	logic signed [33:0] vt_q [3];
	logic [1:0] op_q;
	logic signed [15:0] e_q [3];
	logic signed [16:0] v_q [3];
	logic [23:0] col_q;
	logic [7:0]  u_q, vv_q;
	logic signed [35:0] w_q [3];
	logic signed [39:0] acc_q;
	logic signed [17:0] ma, mb;
	logic signed [35:0] prod;
	logic signed [39:0] rnd;
	logic signed [35:0] wsum;
	logic signed [35:0] z36;
	logic [16:0] nearp;
	logic signed [35:0] w_ax;
	logic [35:0] mag;
	logic [63:0] num;
	logic [63:0] quo;
	logic [31:0] rem;
	logic [31:0] zden;
	logic        busy;
	logic [52:0] full;
	logic signed [53:0] vsgn;
	logic signed [54:0] vsum, vcl;
	logic signed [54:0] vr;
	logic signed [14:0] sx_q, sy_q, px_q, py_q;
	logic [1:0]  ri;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 3; n++) begin cam_q[n] <= '0; ct_q[n] <= '0; end
			h_q <= 16'd256; off_q[0] <= '0; off_q[1] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAM_ROW0:  cam_q[0] <= cfg_data[47:0];
				REG_CAM_ROW1:  cam_q[1] <= cfg_data[47:0];
				REG_CAM_ROW2:  cam_q[2] <= cfg_data[47:0];
				REG_CAM_TXY:   begin ct_q[0] <= cfg_data[31:0]; ct_q[1] <= cfg_data[63:32]; end
				REG_CAM_TZ:    ct_q[2] <= cfg_data[31:0];
				REG_PROJ_DIST: h_q <= cfg_data[15:0];
				REG_SCR_OFF:   begin off_q[0] <= cfg_data[31:0]; off_q[1] <= cfg_data[63:32]; end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= operation;
			e_q[0] <= elem_a; e_q[1] <= elem_b; e_q[2] <= elem_c;
			v_q[0] <= 17'(signed'({vert_x, 8'd0}));
			v_q[1] <= 17'(signed'({vert_y, 8'd0}));
			v_q[2] <= 17'(signed'({vert_z, 8'd0}));
			col_q <= color_word; u_q <= uv_u; vv_q <= uv_v;
		end
	end
	assign stat.op = op_q;
	assign stat.in_op = operation;
	assign ri = row_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 9; n++) begin om_q[n] <= '0; vm_q[n] <= '0; end
			for (int n = 0; n < 3; n++) vt_q[n] <= '0;
		end else begin
			if (cmd.load_in && operation == OP_LOAD_ROW && ri != 2'd3) begin
				om_q[ri*3+0] <= elem_a; om_q[ri*3+1] <= elem_b; om_q[ri*3+2] <= elem_c;
			end
			if (cmd.store_vm) begin
				if (rnd > 40'sd131071) vm_q[cmd.i*3+cmd.j] <= 18'sd131071;
				else if (rnd < -40'sd131072) vm_q[cmd.i*3+cmd.j] <= -18'sd131072;
				else vm_q[cmd.i*3+cmd.j] <= rnd[17:0];
			end
			if (cmd.store_vt) vt_q[cmd.i] <= 34'(ct_q[cmd.i]) + rnd[33:0];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		if (op_q == OP_VERTEX) begin
			ma = vm_q[cmd.i*3+cmd.k];
			mb = 18'(v_q[cmd.k]);
		end else begin
			ma = 18'(signed'(cam_q[cmd.i][16*cmd.k +: 16]));
			mb = cmd.is_trans ? 18'(e_q[cmd.k]) : 18'(om_q[cmd.k*3+cmd.j]);
		end
	end
	assign prod = ma * mb;
	assign rnd  = (acc_q + 40'sd2048) >>> 12;
	assign wsum = 36'(rnd) + 36'(vt_q[cmd.i]);

	always_ff @(posedge clk) begin
		if (cmd.clear_acc) acc_q <= '0;
		else if (cmd.mac) acc_q <= acc_q + 40'(prod);
		if (cmd.store_w) w_q[cmd.i] <= wsum;
	end

	// near plane is at least one view unit, even for H of zero
	assign nearp = (h_q == 16'd0) ? 17'd1 : ({1'b0, h_q} + 17'd1) >> 1;
	assign z36 = (w_q[2] < $signed(36'(nearp))) ? 36'(nearp) : w_q[2];
	assign zden = (z36 > 36'sd4294967295) ? 32'hFFFFFFFF : z36[31:0];
	assign w_ax = cmd.div_axis ? w_q[1] : w_q[0];
	assign mag  = w_ax[35] ? 36'(-w_ax) : w_ax;
	assign num  = {48'(mag * {20'd0, h_q}), 16'd0};

	// |w|*H << 16 / z in one pass: quotient holds integer and fraction
	vtp_div #(.NW(64), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num), .den(zden), .busy(busy), .quo(quo), .rem(rem)
	);
	assign stat.div_busy = busy;

	always_comb begin
		full = (quo[63:16] > 48'd1048576) ? 53'(64'd1048576 << 16) : quo[52:0];
		vsgn = w_ax[35] ? -54'(full) : 54'(full);
		vsum = 55'(vsgn) + 55'(cmd.div_axis ? off_q[1] : off_q[0]);
		if (vsum < -55'sd67108864) vcl = -55'sd67108864;
		else if (vsum > 55'sd67043328) vcl = 55'sd67043328;
		else vcl = vsum;
		vr = (vcl + 55'(56'sd1 <<< (SH - 1))) >>> SH;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_axis) begin
			if (cmd.div_axis) py_q <= vr[14:0];
			else px_q <= vr[14:0];
		end
		if (cmd.out_load) begin
			sx_q <= px_q; sy_q <= py_q;
		end
	end
	assign screen_x = sx_q;
	assign screen_y = sy_q;
	assign depth_z  = (z36 > 36'sd2147483647) ? 31'h7FFFFFFF : z36[30:0];
	assign red   = col_q[7:0];
	assign green = col_q[15:8];
	assign blue  = col_q[23:16];
	assign tex_u = u_q;
	assign tex_v = vv_q;
	logic unused;
	assign unused = ^rem;
endmodule

// ===== rtl/core/vertex_transform_project_core.sv =====
// Vertex transform and perspective project core: top level.
// Load row stores the beat; compose and vertex run MAC and store steps; vertex adds two divides.
// One item at a time, none while a result waits; vertex rate set by the bit-serial H/z divider.
// Reset: arst_n clears control, matrices and config (H resets to 256).
// Depends on vtp_pkg, vtp_ctrl, vtp_datapath, vtp_div and assert_macros.svh.
`include "assert_macros.svh"
module vertex_transform_project_core #(
	parameter int SCREEN_FRAC_BITS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [1:0]         row_index,
	input  logic signed [15:0] elem_a,
	input  logic signed [15:0] elem_b,
	input  logic signed [15:0] elem_c,
	input  logic signed [7:0]  vert_x,
	input  logic signed [7:0]  vert_y,
	input  logic signed [7:0]  vert_z,
	input  logic [23:0]        color_word,
	input  logic [7:0]         uv_u,
	input  logic [7:0]         uv_v,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] screen_x,
	output logic signed [14:0] screen_y,
	output logic [30:0]        depth_z,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [7:0]         tex_u,
	output logic [7:0]         tex_v
);
	import vtp_pkg::*;
	cmd_t  cmd;
	stat_t stat;

	// sequencer: takes one beat, walks the MAC and divide steps
	vtp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	vtp_datapath #(.SCREEN_FRAC_BITS(SCREEN_FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .operation(operation), .row_index(row_index),
		.elem_a(elem_a), .elem_b(elem_b), .elem_c(elem_c),
		.vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
		.color_word(color_word), .uv_u(uv_u), .uv_v(uv_v),
		.cmd(cmd), .stat(stat),
		.screen_x(screen_x), .screen_y(screen_y), .depth_z(depth_z),
		.red(red), .green(green), .blue(blue), .tex_u(tex_u), .tex_v(tex_v)
	);

	// no new beat while a result waits
	`ASSERT_IMPL(a_no_accept_with_result, clk, arst_n, out_valid, !in_ready)
	// a held result stays until taken
	`ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(screen_x))
	// divider is never restarted while busy
	`ASSERT_IMPL(a_div_idle_on_start, clk, arst_n, cmd.div_start, !stat.div_busy)
endmodule

// ===== bench/vertex_transform_project_core_tb.sv =====
// Self-checking bench for vertex_transform_project_core: directed table, then random phases.
// Depends on vtp_pkg and the core RTL; the expected beats come from an in-bench predictor.
module vertex_transform_project_core_tb;
	import vtp_pkg::*;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES  = 300;

	// one input beat, plus a typed expectation for the rows where it is obvious
	typedef struct {
		logic [1:0]  op;
		logic [1:0]  row;
		logic [15:0] a, b, c;
		logic [7:0]  x, y, z;
		logic [23:0] color;
		logic [7:0]  u, v;
		bit          typed;
		logic [14:0] sx, sy;
		logic [30:0] dz;
	} beat_t;

	typedef struct {
		logic [14:0] sx, sy;
		logic [30:0] dz;
		logic [7:0]  r, g, b, u, v;
	} vertex_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = '0, row_index = '0;
	logic signed [15:0] elem_a = '0, elem_b = '0, elem_c = '0;
	logic signed [7:0] vert_x = '0, vert_y = '0, vert_z = '0;
	logic [23:0] color_word = '0;
	logic [7:0] uv_u = '0, uv_v = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [14:0] screen_x, screen_y;
	logic [30:0] depth_z;
	logic [7:0] red, green, blue, tex_u, tex_v;

	vertex_transform_project_core u_dut (.*);

	always #5 clk = ~clk;

	// shadow of the configuration and of the block's matrices
	logic [47:0] cam_row [3];
	logic [63:0] cam_txy, scr_off;
	logic [31:0] cam_tz;
	logic [15:0] h_dist;
	longint obj_m [9];
	longint view_m [9];
	longint view_t [3];

	vertex_out_t pending_vertices [$];
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;

	function automatic longint rnd12(longint v);
		return (v + 2048) >>> 12;
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint cam_el(int r, int c);
		logic [15:0] e;
		e = cam_row[r][16*c +: 16];
		return longint'($signed(e));
	endfunction

	// w*H/z with 16 fraction bits, plus offset, clamped, rounded to screen precision
	function automatic longint project_axis(longint w, longint h, longint z, longint off);
		longint mag, prod, q, r, fr, v;
		mag = w < 0 ? -w : w;
		prod = mag * h;
		q = prod / z;
		r = prod % z;
		if (q > (longint'(1) << 20)) begin
			q = longint'(1) << 20;
			fr = 0;
		end else begin
			fr = (r << 16) / z;
		end
		v = (q << 16) + fr;
		if (w < 0) v = -v;
		v = clampl(v + off, -1024 * 65536, 1023 * 65536);
		return (v + (longint'(1) << 11)) >>> 12;
	endfunction

	// advance the shadow state by one beat; returns 1 when a vertex result is due
	function automatic bit transform_beat(beat_t bt, output vertex_out_t res);
		longint e [3], ct [3], vv [3], w [3];
		longint s, t, nearp, z, h;
		e[0] = longint'($signed(bt.a));
		e[1] = longint'($signed(bt.b));
		e[2] = longint'($signed(bt.c));
		res = '{default: '0};
		case (bt.op)
			OP_LOAD_ROW: begin
				if (bt.row != 2'd3)
					for (int j = 0; j < 3; j++) obj_m[bt.row*3 + j] = e[j];
				return 1'b0;
			end
			OP_COMPOSE: begin
				ct[0] = longint'($signed(cam_txy[31:0]));
				ct[1] = longint'($signed(cam_txy[63:32]));
				ct[2] = longint'($signed(cam_tz));
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						s = 0;
						for (int k = 0; k < 3; k++) s += cam_el(i, k) * obj_m[k*3 + j];
						view_m[i*3 + j] = clampl(rnd12(s), -131072, 131071);
					end
					t = 0;
					for (int k = 0; k < 3; k++) t += cam_el(i, k) * e[k];
					view_t[i] = ct[i] + rnd12(t);
				end
				return 1'b0;
			end
			OP_VERTEX: begin
				vv[0] = longint'($signed(bt.x)) * 256;
				vv[1] = longint'($signed(bt.y)) * 256;
				vv[2] = longint'($signed(bt.z)) * 256;
				for (int i = 0; i < 3; i++) begin
					s = 0;
					for (int k = 0; k < 3; k++) s += view_m[i*3 + k] * vv[k];
					w[i] = rnd12(s) + view_t[i];
				end
				h = longint'(h_dist);
				nearp = (h + 1) >> 1;
				if (nearp < 1) nearp = 1;
				z = w[2] < nearp ? nearp : w[2];
				res.sx = 15'(project_axis(w[0], h, z, longint'($signed(scr_off[31:0]))));
				res.sy = 15'(project_axis(w[1], h, z, longint'($signed(scr_off[63:32]))));
				res.dz = 31'(z > 64'sd2147483647 ? 64'sd2147483647 : z);
				res.r = bt.color[7:0];
				res.g = bt.color[15:8];
				res.b = bt.color[23:16];
				res.u = bt.u;
				res.v = bt.v;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic int gap_len();
		int p;
		if (calm) return 0;
		p = $urandom_range(99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// write one register at a negedge and update the shadow copy
	task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CAM_ROW0:  cam_row[0] = data[47:0];
			REG_CAM_ROW1:  cam_row[1] = data[47:0];
			REG_CAM_ROW2:  cam_row[2] = data[47:0];
			REG_CAM_TXY:   cam_txy = data;
			REG_CAM_TZ:    cam_tz = data[31:0];
			REG_PROJ_DIST: h_dist = data[15:0];
			REG_SCR_OFF:   scr_off = data;
			default: ;
		endcase
	endtask

	// present one beat, hold it until accepted, then predict
	task automatic send_beat(beat_t bt);
		vertex_out_t res;
		int n;
		n = gap_len();
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= bt.op;
		row_index <= bt.row;
		elem_a <= bt.a;
		elem_b <= bt.b;
		elem_c <= bt.c;
		vert_x <= bt.x;
		vert_y <= bt.y;
		vert_z <= bt.z;
		color_word <= bt.color;
		uv_u <= bt.u;
		uv_v <= bt.v;
		do @(posedge clk); while (!in_ready);
		if (transform_beat(bt, res)) begin
			if (bt.typed) begin
				res.sx = bt.sx;
				res.sy = bt.sy;
				res.dz = bt.dz;
			end
			pending_vertices.push_back(res);
		end
	endtask

	// drop valid, drain every expected vertex, then let any load finish
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic beat_t rand_beat(logic [1:0] op);
		beat_t bt;
		bt.op = op;
		bt.row = 2'($urandom_range(2));
		bt.a = 16'($urandom);
		bt.b = 16'($urandom);
		bt.c = 16'($urandom);
		bt.x = 8'($urandom);
		bt.y = 8'($urandom);
		bt.z = 8'($urandom);
		bt.color = 24'($urandom);
		bt.u = 8'($urandom);
		bt.v = 8'($urandom);
		bt.typed = 1'b0;
		bt.sx = '0;
		bt.sy = '0;
		bt.dz = '0;
		return bt;
	endfunction

	// matrix element: mostly near unit scale, sometimes anywhere in range
	function automatic logic [15:0] rand_elem();
		if ($urandom_range(3) == 0) return 16'($urandom);
		return 16'($urandom_range(8192) - 4096);
	endfunction

	function automatic logic [47:0] rand_cam_row(int mode);
		if (mode == 0) return {3{16'h8000}};
		if (mode == 1) return {3{16'h7fff}};
		return {rand_elem(), rand_elem(), rand_elem()};
	endfunction

	// check every output beat against the oldest expectation
	always @(posedge clk) begin
		vertex_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_vertices.size() == 0) begin
				report("unexpected vertex beat", screen_x, 0);
			end else begin
				want = pending_vertices.pop_front();
				if (screen_x !== want.sx) report("screen_x", $signed(screen_x), $signed(want.sx));
				if (screen_y !== want.sy) report("screen_y", $signed(screen_y), $signed(want.sy));
				if (depth_z !== want.dz) report("depth_z", depth_z, want.dz);
				if (red !== want.r) report("red", red, want.r);
				if (green !== want.g) report("green", green, want.g);
				if (blue !== want.b) report("blue", blue, want.b);
				if (tex_u !== want.u) report("tex_u", tex_u, want.u);
				if (tex_v !== want.v) report("tex_v", tex_v, want.v);
			end
		end
	end

	// watchdog: count cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// result side: stall the receiver at random
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = gap_len();
			@(negedge clk);
			if (n == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		beat_t table_rows [$];
		beat_t bt;
		int hsel, vcount;
		logic [63:0] d;

		cam_row[0] = '0;
		cam_row[1] = '0;
		cam_row[2] = '0;
		cam_txy = '0;
		cam_tz = '0;
		h_dist = 16'd256;
		scr_off = '0;
		for (int i = 0; i < 9; i++) begin
			obj_m[i] = 0;
			view_m[i] = 0;
		end
		for (int i = 0; i < 3; i++) view_t[i] = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// after reset everything projects to the offset at the near plane (H/2 = 128)
		bt = rand_beat(OP_VERTEX);
		bt.x = 8'h7f; bt.y = 8'h80; bt.z = 8'h7f;
		bt.color = 24'hffffff; bt.u = 8'hff; bt.v = 8'hff;
		bt.typed = 1'b1; bt.sx = '0; bt.sy = '0; bt.dz = 31'd128;
		table_rows.push_back(bt);
		bt = rand_beat(OP_VERTEX);
		bt.x = 8'h80; bt.y = 8'h7f; bt.z = 8'h80;
		bt.color = 24'h000000; bt.u = 8'h00; bt.v = 8'h00;
		bt.typed = 1'b1; bt.sx = '0; bt.sy = '0; bt.dz = 31'd128;
		table_rows.push_back(bt);
		// compose with zero camera leaves the view zero as well
		bt = rand_beat(OP_COMPOSE);
		table_rows.push_back(bt);
		bt = rand_beat(OP_VERTEX);
		bt.typed = 1'b1; bt.sx = '0; bt.sy = '0; bt.dz = 31'd128;
		table_rows.push_back(bt);
		foreach (table_rows[i]) send_beat(table_rows[i]);
		drain();

		// identity camera and object rows, ignored rows and codes, then vertices at the extremes
		cfg_write(REG_CAM_ROW0, {16'h0000, 16'h0000, 16'h1000});
		cfg_write(REG_CAM_ROW1, {16'h0000, 16'h1000, 16'h0000});
		cfg_write(REG_CAM_ROW2, {16'h1000, 16'h0000, 16'h0000});
		table_rows.delete();
		bt = rand_beat(OP_LOAD_ROW); bt.row = 2'd0;
		bt.a = 16'h1000; bt.b = 16'h0000; bt.c = 16'h0000; table_rows.push_back(bt);
		bt = rand_beat(OP_LOAD_ROW); bt.row = 2'd1;
		bt.a = 16'h0000; bt.b = 16'h1000; bt.c = 16'h0000; table_rows.push_back(bt);
		bt = rand_beat(OP_LOAD_ROW); bt.row = 2'd2;
		bt.a = 16'h0000; bt.b = 16'h0000; bt.c = 16'h1000; table_rows.push_back(bt);
		bt = rand_beat(OP_LOAD_ROW); bt.row = 2'd3; table_rows.push_back(bt);
		bt = rand_beat(2'd3); table_rows.push_back(bt);
		bt = rand_beat(OP_COMPOSE);
		bt.a = 16'h0000; bt.b = 16'h0000; bt.c = 16'h0400; table_rows.push_back(bt);
		bt = rand_beat(OP_VERTEX);
		bt.x = 8'h7f; bt.y = 8'h7f; bt.z = 8'h7f; table_rows.push_back(bt);
		bt = rand_beat(OP_VERTEX);
		bt.x = 8'h80; bt.y = 8'h80; bt.z = 8'h80; table_rows.push_back(bt);
		bt = rand_beat(OP_VERTEX);
		bt.x = 8'h00; bt.y = 8'h00; bt.z = 8'h00; table_rows.push_back(bt);
		// full-scale object rows and translation, then extreme vertices
		for (int r = 0; r < 3; r++) begin
			bt = rand_beat(OP_LOAD_ROW); bt.row = 2'(r);
			bt.a = 16'h8000; bt.b = 16'h7fff; bt.c = 16'h8000; table_rows.push_back(bt);
		end
		bt = rand_beat(OP_COMPOSE);
		bt.a = 16'h7fff; bt.b = 16'h8000; bt.c = 16'h7fff; table_rows.push_back(bt);
		bt = rand_beat(OP_VERTEX);
		bt.x = 8'h7f; bt.y = 8'h80; bt.z = 8'h7f; table_rows.push_back(bt);
		bt = rand_beat(OP_VERTEX);
		bt.x = 8'h80; bt.y = 8'h7f; bt.z = 8'h80; table_rows.push_back(bt);
		foreach (table_rows[i]) send_beat(table_rows[i]);
		drain();

		// odd H and large depth before the random part
		cfg_write(REG_PROJ_DIST, 64'd257);
		cfg_write(REG_CAM_TZ, 64'h7fff_ffff);
		send_beat(rand_beat(OP_COMPOSE));
		send_beat(rand_beat(OP_VERTEX));
		send_beat(rand_beat(OP_VERTEX));
		drain();
		cfg_write(REG_CAM_TZ, 64'h8000_0000);
		send_beat(rand_beat(OP_COMPOSE));
		send_beat(rand_beat(OP_VERTEX));
		drain();

		// random phases: new settings, a well-formed load and usually a compose, then mostly vertices
		for (int ph = 0; ph < 10; ph++) begin
			calm = (ph % 4 == 3);
			if (ph < 2 || $urandom_range(1)) begin
				for (int r = 0; r < 3; r++)
					cfg_write(3'(r), {16'($urandom), rand_cam_row(ph < 2 ? ph : 2)});
			end
			d = {$urandom, $urandom};
			if (ph == 2) d = 64'h8000_0000_7fff_ffff;
			else if ($urandom_range(1)) d = {32'($urandom_range(4000) - 2000),
				32'($urandom_range(4000) - 2000)};
			cfg_write(REG_CAM_TXY, d);
			d = {32'($urandom), $urandom};
			if ($urandom_range(1)) d = {32'($urandom), 32'($urandom_range(3000))};
			cfg_write(REG_CAM_TZ, d);
			hsel = $urandom_range(7);
			case (hsel)
				0: d = 64'd0;
				1: d = 64'd1;
				2: d = 64'd3;
				3: d = 64'hffff;
				4: d = {48'($urandom), 16'($urandom)};
				default: d = {48'($urandom), 16'($urandom_range(1024, 64))};
			endcase
			cfg_write(REG_PROJ_DIST, d);
			d = {$urandom, $urandom};
			if (ph == 4) d = 64'h8000_0000_7fff_ffff;
			else if ($urandom_range(2) != 0) d = {32'($urandom_range(2 * 65536 * 600) - 65536 * 600),
				32'($urandom_range(2 * 65536 * 600) - 65536 * 600)};
			cfg_write(REG_SCR_OFF, d);

			for (int r = 0; r < 3; r++) begin
				bt = rand_beat(OP_LOAD_ROW);
				bt.row = 2'(r);
				bt.a = rand_elem(); bt.b = rand_elem(); bt.c = rand_elem();
				send_beat(bt);
			end
			// sometimes skip the compose so a new camera must not show yet
			if (ph < 2 || $urandom_range(4) != 0) begin
				bt = rand_beat(OP_COMPOSE);
				if ($urandom_range(1)) begin
					bt.a = 16'($urandom_range(2000) - 1000);
					bt.b = 16'($urandom_range(2000) - 1000);
					bt.c = 16'($urandom_range(2000));
				end
				send_beat(bt);
			end
			vcount = $urandom_range(50, 35);
			for (int n = 0; n < vcount; n++) begin
				case ($urandom_range(19))
					0: bt = rand_beat(2'd3);
					1: begin
						bt = rand_beat(OP_LOAD_ROW);
						bt.row = 2'd3;
					end
					2: bt = rand_beat(OP_LOAD_ROW);
					3: bt = rand_beat(OP_COMPOSE);
					default: bt = rand_beat(OP_VERTEX);
				endcase
				send_beat(bt);
			end
			drain();
		end

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/vtp_pkg.sv
rtl/core/vtp_div.sv
rtl/core/vtp_ctrl.sv
rtl/core/vtp_datapath.sv
rtl/core/vertex_transform_project_core.sv
bench/vertex_transform_project_core_tb.sv
